[sv/i64div_pkg.sv]
package i64div_pkg;

    localparam int DATA_WIDTH_DEFAULT = 64;
    localparam int PORT_WIDTH = 64;

    // Control that travels with every pipeline stage.
    typedef struct packed {
        logic valid;
        logic negate;
        logic div_zero;
    } stage_ctrl_t;

endpackage

[sv/i64div_step.sv]
// One restoring shift-subtract step: brings in the next dividend bit,
// subtracts the divisor when it fits and records one quotient bit.
module i64div_step #(
    parameter int DATA_WIDTH = i64div_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  i64div_pkg::stage_ctrl_t ctrl_in,
    input  logic [DATA_WIDTH-1:0] rem_in,
    input  logic [DATA_WIDTH-1:0] num_in,
    input  logic [DATA_WIDTH-1:0] den_in,
    output i64div_pkg::stage_ctrl_t ctrl_out,
    output logic [DATA_WIDTH-1:0] rem_out,
    output logic [DATA_WIDTH-1:0] num_out,
    output logic [DATA_WIDTH-1:0] den_out
);

    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] num_next;

    i64div_pkg::stage_ctrl_t ctrl_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] num_reg;
    logic [DATA_WIDTH-1:0] den_reg;

    // The quotient bits fill num from the bottom as dividend bits leave the top.
    always_comb begin
        shifted  = {rem_in, num_in[DATA_WIDTH-1]};
        diff     = shifted - {1'b0, den_in};
        fits     = !diff[DATA_WIDTH];
        rem_next = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
        num_next = {num_in[DATA_WIDTH-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (advance) begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rem_reg <= rem_next;
            num_reg <= num_next;
            den_reg <= den_in;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign rem_out  = rem_reg;
    assign num_out  = num_reg;
    assign den_out  = den_reg;

endmodule

[sv/int64_divider_signed_unsigned.sv]
// Pipelined 64-bit integer divider, unsigned or signed.
// The s_ channel takes a transaction of kind, dividend and divisor; kind 0
// divides unsigned, kind 1 divides two's complement values. The m_ channel
// returns one transaction per input: the quotient truncated toward zero and
// a divide_by_zero flag. A zero divisor yields an all-ones quotient with the
// flag set. The most negative value divided by minus one wraps to itself.
// One stage takes operand magnitudes, DATA_WIDTH stages each produce one
// quotient bit, and a last stage applies the sign and holds the result.
// A new transaction may enter every cycle while the receiver does not stall,
// so throughput is one per cycle when the output is not held.
// The whole pipeline advances together whenever the output register is
// empty or being read; when the receiver stalls with a result waiting,
// every stage holds, and s_ready drops, so nothing is lost or repeated.
// Reset clears all valid bits; data registers are not reset.
module int64_divider_signed_unsigned #(
    parameter int DATA_WIDTH = i64div_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [i64div_pkg::PORT_WIDTH-1:0] s_dividend,
    input  logic [i64div_pkg::PORT_WIDTH-1:0] s_divisor,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [i64div_pkg::PORT_WIDTH-1:0] m_quotient,
    output logic                              m_divide_by_zero
);

    logic advance;

    // Input stage: magnitudes and sign.
    logic [DATA_WIDTH-1:0] n_raw;
    logic [DATA_WIDTH-1:0] d_raw;
    logic                  n_neg;
    logic                  d_neg;
    i64div_pkg::stage_ctrl_t in_ctrl_next;
    i64div_pkg::stage_ctrl_t in_ctrl_reg;
    logic [DATA_WIDTH-1:0] in_num_reg;
    logic [DATA_WIDTH-1:0] in_den_reg;

    // Output stage.
    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] out_quot_reg;
    logic [DATA_WIDTH-1:0] out_quot_next;
    logic                  out_dz_reg;

    // Step chain wiring: index 0 is the input stage.
    i64div_pkg::stage_ctrl_t ctrl_c [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0]   rem_c  [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0]   num_c  [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0]   den_c  [DATA_WIDTH+1];

    // Every stage moves when the output register can accept a result.
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = advance;

    always_comb begin
        n_raw = s_dividend[DATA_WIDTH-1:0];
        d_raw = s_divisor[DATA_WIDTH-1:0];
        n_neg = s_kind && n_raw[DATA_WIDTH-1];
        d_neg = s_kind && d_raw[DATA_WIDTH-1];
        in_ctrl_next.valid    = s_valid;
        in_ctrl_next.negate   = n_neg ^ d_neg;
        in_ctrl_next.div_zero = (d_raw == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ctrl_reg <= '0;
        end else if (advance) begin
            in_ctrl_reg <= in_ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            in_num_reg <= n_neg ? -n_raw : n_raw;
            in_den_reg <= d_neg ? -d_raw : d_raw;
        end
    end

    assign ctrl_c[0] = in_ctrl_reg;
    assign rem_c[0]  = '0;
    assign num_c[0]  = in_num_reg;
    assign den_c[0]  = in_den_reg;

    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_step
        i64div_step #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .ctrl_in (ctrl_c[g]),
            .rem_in  (rem_c[g]),
            .num_in  (num_c[g]),
            .den_in  (den_c[g]),
            .ctrl_out(ctrl_c[g+1]),
            .rem_out (rem_c[g+1]),
            .num_out (num_c[g+1]),
            .den_out (den_c[g+1])
        );
    end

    // A zero divisor makes every step fit, but force all ones explicitly.
    always_comb begin
        if (ctrl_c[DATA_WIDTH].div_zero) begin
            out_quot_next = '1;
        end else if (ctrl_c[DATA_WIDTH].negate) begin
            out_quot_next = -num_c[DATA_WIDTH];
        end else begin
            out_quot_next = num_c[DATA_WIDTH];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= ctrl_c[DATA_WIDTH].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_quot_reg <= out_quot_next;
            out_dz_reg   <= ctrl_c[DATA_WIDTH].div_zero;
        end
    end

    assign m_valid = out_valid_reg;

    // Bits above DATA_WIDTH on the result port are zero.
    always_comb begin
        m_quotient                 = '0;
        m_quotient[DATA_WIDTH-1:0] = out_quot_reg;
    end

    assign m_divide_by_zero = out_dz_reg;

    // A stalled result must hold until taken.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_quotient))
        else $error("result changed while stalled");

    // Input is refused exactly when a result waits unread.
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("ready does not follow output state");

    // A divide by zero result always carries an all-ones quotient.
    a_dz_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_by_zero |-> out_quot_reg == '1)
        else $error("divide by zero quotient not all ones");

endmodule
